// File: sv/adpcm8_pkg.sv
// ----------------------------------------------------------------------------
// adpcm8_pkg
// Shared types, constants and tables for the 8-bit ADPCM sample decoder.
// ----------------------------------------------------------------------------
package adpcm8_pkg;

	// Highest legal step table index.
	localparam int unsigned STEP_MAX_INDEX = 88;

	// Configuration register byte address.
	localparam logic [1:0] REG_STEREO_MODE = 2'd0;

	// Per-channel decoder state.
	typedef struct packed {
		logic signed [15:0] predictor;
		logic [6:0]         step_index;
	} chan_state_t;

	// IMA step table. Any index above the table end reads the last entry.
	function automatic logic [14:0] step_size(input logic [6:0] idx);
		logic [14:0] s;
		case (idx)
			7'd0:  s = 15'h0007;  7'd1:  s = 15'h0008;  7'd2:  s = 15'h0009;
			7'd3:  s = 15'h000A;  7'd4:  s = 15'h000B;  7'd5:  s = 15'h000C;
			7'd6:  s = 15'h000D;  7'd7:  s = 15'h000E;  7'd8:  s = 15'h0010;
			7'd9:  s = 15'h0011;  7'd10: s = 15'h0013;  7'd11: s = 15'h0015;
			7'd12: s = 15'h0017;  7'd13: s = 15'h0019;  7'd14: s = 15'h001C;
			7'd15: s = 15'h001F;  7'd16: s = 15'h0022;  7'd17: s = 15'h0025;
			7'd18: s = 15'h0029;  7'd19: s = 15'h002D;  7'd20: s = 15'h0032;
			7'd21: s = 15'h0037;  7'd22: s = 15'h003C;  7'd23: s = 15'h0042;
			7'd24: s = 15'h0049;  7'd25: s = 15'h0050;  7'd26: s = 15'h0058;
			7'd27: s = 15'h0061;  7'd28: s = 15'h006B;  7'd29: s = 15'h0076;
			7'd30: s = 15'h0082;  7'd31: s = 15'h008F;  7'd32: s = 15'h009D;
			7'd33: s = 15'h00AD;  7'd34: s = 15'h00BE;  7'd35: s = 15'h00D1;
			7'd36: s = 15'h00E6;  7'd37: s = 15'h00FD;  7'd38: s = 15'h0117;
			7'd39: s = 15'h0133;  7'd40: s = 15'h0151;  7'd41: s = 15'h0173;
			7'd42: s = 15'h0198;  7'd43: s = 15'h01C1;  7'd44: s = 15'h01EE;
			7'd45: s = 15'h0220;  7'd46: s = 15'h0256;  7'd47: s = 15'h0292;
			7'd48: s = 15'h02D4;  7'd49: s = 15'h031C;  7'd50: s = 15'h036C;
			7'd51: s = 15'h03C3;  7'd52: s = 15'h0424;  7'd53: s = 15'h048E;
			7'd54: s = 15'h0502;  7'd55: s = 15'h0583;  7'd56: s = 15'h0610;
			7'd57: s = 15'h06AB;  7'd58: s = 15'h0756;  7'd59: s = 15'h0812;
			7'd60: s = 15'h08E0;  7'd61: s = 15'h09C3;  7'd62: s = 15'h0ABD;
			7'd63: s = 15'h0BD0;  7'd64: s = 15'h0CFF;  7'd65: s = 15'h0E4C;
			7'd66: s = 15'h0FBA;  7'd67: s = 15'h114C;  7'd68: s = 15'h1307;
			7'd69: s = 15'h14EE;  7'd70: s = 15'h1706;  7'd71: s = 15'h1954;
			7'd72: s = 15'h1BDC;  7'd73: s = 15'h1EA5;  7'd74: s = 15'h21B6;
			7'd75: s = 15'h2515;  7'd76: s = 15'h28CA;  7'd77: s = 15'h2CDF;
			7'd78: s = 15'h315B;  7'd79: s = 15'h364B;  7'd80: s = 15'h3BB9;
			7'd81: s = 15'h41B2;  7'd82: s = 15'h4844;  7'd83: s = 15'h4F7E;
			7'd84: s = 15'h5771;  7'd85: s = 15'h602F;  7'd86: s = 15'h69CE;
			7'd87: s = 15'h7462;
			default: s = 15'h7FFF;
		endcase
		return s;
	endfunction

	// Step index adjustment selected by code bits 6..4.
	function automatic logic signed [4:0] index_adjust(input logic [2:0] sel);
		logic signed [4:0] a;
		case (sel)
			3'd3:    a = 5'sd1;
			3'd4:    a = 5'sd4;
			3'd5:    a = 5'sd7;
			3'd6:    a = 5'sd10;
			3'd7:    a = 5'sd12;
			default: a = -5'sd1;
		endcase
		return a;
	endfunction

endpackage

// File: sv/adpcm8_apb.sv
// ----------------------------------------------------------------------------
// adpcm8_apb
// APB register slave holding the stereo mode control bit.
// ----------------------------------------------------------------------------
module adpcm8_apb
	import adpcm8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        stereo_mode
);

	logic stereo_mode_q;

	// The register is written in the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr == REG_STEREO_MODE)) begin
			stereo_mode_q <= pwdata[0];
		end
	end

	// Read data; unmapped addresses read as zero.
	assign prdata      = (paddr == REG_STEREO_MODE) ? {31'd0, stereo_mode_q} : 32'd0;
	assign pready      = 1'b1;
	assign stereo_mode = stereo_mode_q;

endmodule

// File: sv/adpcm8_datapath.sv
// ----------------------------------------------------------------------------
// adpcm8_datapath
// Combinational decode of one code against one channel's state.
// ----------------------------------------------------------------------------
module adpcm8_datapath
	import adpcm8_pkg::*;
(
	input  logic [7:0]  code,
	input  chan_state_t cur,
	output chan_state_t nxt
);

	logic [6:0]         idx_c;
	logic [14:0]        step;
	logic [16:0]        mag;
	logic signed [17:0] pred_ext;
	logic signed [17:0] mag_ext;
	logic signed [17:0] total;
	logic signed [4:0]  adj;
	logic signed [8:0]  nidx;

	always_comb begin
		// Clamp the stored index and fetch the step.
		idx_c = (cur.step_index > 7'(STEP_MAX_INDEX)) ? 7'(STEP_MAX_INDEX) : cur.step_index;
		step  = step_size(idx_c);

		// Each magnitude bit adds a shifted copy of the step.
		mag = '0;
		for (int k = 0; k < 7; k++) begin
			if (code[k]) begin
				mag = mag + 17'(step >> (6 - k));
			end
		end

		// Apply the sign to the predictor and saturate to 16 bits.
		pred_ext = {{2{cur.predictor[15]}}, cur.predictor};
		mag_ext  = {1'b0, mag};
		total    = code[7] ? (pred_ext - mag_ext) : (pred_ext + mag_ext);
		if (total > 18'sd32767) begin
			nxt.predictor = 16'sh7FFF;
		end else if (total < -18'sd32768) begin
			nxt.predictor = 16'sh8000;
		end else begin
			nxt.predictor = total[15:0];
		end

		// Move the step index and clamp it to the table range.
		adj  = index_adjust(code[6:4]);
		nidx = $signed({2'b00, idx_c}) + 9'(adj);
		if (nidx[8]) begin
			nxt.step_index = 7'd0;
		end else if (nidx > 9'sd88) begin
			nxt.step_index = 7'(STEP_MAX_INDEX);
		end else begin
			nxt.step_index = nidx[6:0];
		end
	end

endmodule

// File: sv/adpcm_8bit_sample_decoder.sv
// ----------------------------------------------------------------------------
// adpcm_8bit_sample_decoder
// Decodes 8-bit sign-magnitude ADPCM codes into signed 16-bit PCM samples,
// with an optional two-channel interleave.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+--------------------------------------
//  input   | in_valid / in_ready    | code[7:0], last
//  output  | out_valid / out_ready  | sample[15:0] signed, channel, last_out
//  config  | APB psel/penable/...   | stereo_mode at byte address 0
//
//  One code is accepted per cycle while out_ready does not stall the output;
//  a result passes through the input register, then the result register.
//  Throughput is set by the channel state update loop.
//  Reset clears all channel state, the channel pointer and stereo mode.
//  When the result register is held by out_ready low, the input register
//  fills and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module adpcm_8bit_sample_decoder
	import adpcm8_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Code input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         code,
	input  logic               last,
	// Sample output
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               channel,
	output logic               last_out,
	// Configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic               stereo_mode;
	logic               valid_s1;
	logic [7:0]         code_s1;
	logic               last_s1;
	logic               advance;
	chan_state_t        chan_q [2];
	logic               chan_sel_q;
	chan_state_t        cur_state;
	chan_state_t        nxt_state;
	logic               out_valid_q;
	logic signed [15:0] sample_q;
	logic               channel_q;
	logic               last_out_q;

	adpcm8_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.stereo_mode(stereo_mode)
	);

	// Input stage moves on whenever the result register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= code;
			last_s1 <= last;
		end
	end

	// Decode against the selected channel's state.
	assign cur_state = chan_q[chan_sel_q];

	adpcm8_datapath u_datapath (
		.code(code_s1),
		.cur (cur_state),
		.nxt (nxt_state)
	);

	// Channel state update; a transaction marked last clears both channels and the channel pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q[0]  <= '0;
			chan_q[1]  <= '0;
			chan_sel_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				chan_q[0]  <= '0;
				chan_q[1]  <= '0;
				chan_sel_q <= 1'b0;
			end else begin
				chan_q[chan_sel_q] <= nxt_state;
				chan_sel_q         <= ~chan_sel_q & stereo_mode;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q   <= nxt_state.predictor;
			channel_q  <= chan_sel_q;
			last_out_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign channel   = channel_q;
	assign last_out  = last_out_q;

endmodule

// File: sv/adpcm8_checker.sv
// ----------------------------------------------------------------------------
// adpcm8_checker
// Port-level checks on the decoder's handshakes and rate, bound to the top.
// ----------------------------------------------------------------------------
module adpcm8_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] sample,
	input logic               channel,
	input logic               last_out
);

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(channel)
			&& $stable(last_out))
		else $error("stalled result changed");

	// The input side is never blocked while the output side can move.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready || !out_valid) |-> in_ready)
		else $error("input blocked while output can drain");

	// Every accepted code shows up as a result once it has passed the input and result registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted code produced no result");

endmodule

bind adpcm_8bit_sample_decoder adpcm8_checker u_adpcm8_checker (.*);

// File: sim/adpcm_8bit_sample_decoder_checker.sv
// ----------------------------------------------------------------------------
// adpcm_8bit_sample_decoder_checker
// Passive scoreboard for the ADPCM decoder. It follows the configuration
// port and the code stream, computes the PCM sample that each accepted code
// must produce, and compares every output transaction with it in order.
// ----------------------------------------------------------------------------
module adpcm_8bit_sample_decoder_checker
	import adpcm8_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         code,
	input  logic               last,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] sample,
	input  logic               channel,
	input  logic               last_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 pending,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	// IMA step sizes, indexed by the channel's step index.
	localparam int STEP_TABLE [0:88] = '{
		'h0007, 'h0008, 'h0009, 'h000A, 'h000B, 'h000C, 'h000D, 'h000E,
		'h0010, 'h0011, 'h0013, 'h0015, 'h0017, 'h0019, 'h001C, 'h001F,
		'h0022, 'h0025, 'h0029, 'h002D, 'h0032, 'h0037, 'h003C, 'h0042,
		'h0049, 'h0050, 'h0058, 'h0061, 'h006B, 'h0076, 'h0082, 'h008F,
		'h009D, 'h00AD, 'h00BE, 'h00D1, 'h00E6, 'h00FD, 'h0117, 'h0133,
		'h0151, 'h0173, 'h0198, 'h01C1, 'h01EE, 'h0220, 'h0256, 'h0292,
		'h02D4, 'h031C, 'h036C, 'h03C3, 'h0424, 'h048E, 'h0502, 'h0583,
		'h0610, 'h06AB, 'h0756, 'h0812, 'h08E0, 'h09C3, 'h0ABD, 'h0BD0,
		'h0CFF, 'h0E4C, 'h0FBA, 'h114C, 'h1307, 'h14EE, 'h1706, 'h1954,
		'h1BDC, 'h1EA5, 'h21B6, 'h2515, 'h28CA, 'h2CDF, 'h315B, 'h364B,
		'h3BB9, 'h41B2, 'h4844, 'h4F7E, 'h5771, 'h602F, 'h69CE, 'h7462,
		'h7FFF
	};

	// Step index movement, selected by code bits 6..4.
	localparam int INDEX_MOVE [0:7] = '{-1, -1, -1, 1, 4, 7, 10, 12};

	typedef struct {
		logic signed [15:0] sample;
		logic               channel;
		logic               last_out;
	} pcm_result_t;

	// Decoder state as the scoreboard sees it.
	logic               stereo_on;
	logic signed [15:0] chan_pred [2];
	int                 chan_index [2];
	logic               active_chan;

	pcm_result_t expected_samples [$];
	int          mismatch_total;
	int          checked_total;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		mismatch_total++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	function automatic void clear_channels();
		chan_pred[0] = '0;
		chan_pred[1] = '0;
		chan_index[0] = 0;
		chan_index[1] = 0;
		active_chan = 1'b0;
	endfunction

	// Decodes one code on the active channel and advances the state.
	function automatic pcm_result_t decode_code(input logic [7:0] c, input logic lst);
		pcm_result_t r;
		logic        ch;
		int          idx;
		int          step_val;
		int          delta;
		int          value;
		int          next_idx;
		ch = active_chan;
		idx = chan_index[ch];
		if (idx > int'(STEP_MAX_INDEX)) begin
			idx = STEP_MAX_INDEX;
		end
		step_val = STEP_TABLE[idx];

		// Each magnitude bit adds a binary fraction of the step.
		delta = 0;
		for (int k = 6; k >= 0; k--) begin
			if (c[k]) begin
				delta += step_val >> (6 - k);
			end
		end
		if (c[7]) begin
			delta = -delta;
		end

		// Saturate the new predictor to the 16-bit range.
		value = delta + int'(chan_pred[ch]);
		if (value > SAMPLE_MAX) begin
			value = SAMPLE_MAX;
		end else if (value < SAMPLE_MIN) begin
			value = SAMPLE_MIN;
		end

		next_idx = idx + INDEX_MOVE[c[6:4]];
		if (next_idx < 0) begin
			next_idx = 0;
		end else if (next_idx > int'(STEP_MAX_INDEX)) begin
			next_idx = STEP_MAX_INDEX;
		end

		chan_pred[ch] = value[15:0];
		chan_index[ch] = next_idx;
		active_chan = ~ch & stereo_on;

		r.sample = value[15:0];
		r.channel = ch;
		r.last_out = lst;

		// A block boundary starts every channel afresh.
		if (lst) begin
			clear_channels();
		end
		return r;
	endfunction

	// Results are compared before new codes are predicted, so a sample that
	// appears with nothing outstanding is flagged even on a busy edge.
	always @(posedge clk or negedge arst_n) begin
		pcm_result_t want;
		if (!arst_n) begin
			stereo_on = 1'b0;
			clear_channels();
			expected_samples.delete();
			mismatch_total = 0;
			checked_total = 0;
			mismatches <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// Output transaction.
			if (out_valid && out_ready) begin
				checked_total++;
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("sample %0d ch %0d with none outstanding",
						sample, channel));
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want.sample) begin
						report_mismatch($sformatf("sample %0d, expected %0d",
							sample, want.sample));
					end
					if (channel !== want.channel) begin
						report_mismatch($sformatf("channel %b, expected %b",
							channel, want.channel));
					end
					if (last_out !== want.last_out) begin
						report_mismatch($sformatf("last_out %b, expected %b",
							last_out, want.last_out));
					end
				end
			end

			// Input transaction.
			if (in_valid && in_ready) begin
				expected_samples.push_back(decode_code(code, last));
			end

			// Register access phase: track writes, check read data.
			if (psel && penable && pready && paddr == REG_STEREO_MODE) begin
				if (pwrite) begin
					stereo_on = pwdata[0];
				end else if (prdata !== {31'b0, stereo_on}) begin
					report_mismatch($sformatf("stereo_mode read %0h, expected %0h",
						prdata, stereo_on));
				end
			end

			pending <= expected_samples.size();
			mismatches <= mismatch_total;
			checked <= checked_total;
		end
	end

endmodule

// File: sim/adpcm_8bit_sample_decoder_tb.sv
// ----------------------------------------------------------------------------
// adpcm_8bit_sample_decoder_tb
// Drives code bytes and stereo mode writes into the ADPCM decoder with
// random gaps and output stalls. A directed opening covers each index move,
// saturation both ways, block ends and a stereo-to-mono switch on the right
// channel; random phases in both modes follow. The checker module judges
// every sample.
// ----------------------------------------------------------------------------
module adpcm_8bit_sample_decoder_tb
	import adpcm8_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   RANDOM_PHASES = 6;
	localparam int   PHASE_ITEMS = 90;
	localparam logic MODE_MONO = 1'b0;
	localparam logic MODE_STEREO = 1'b1;

	// Mono opening: every index move, climb to the top of the table with
	// positive saturation, negative saturation, a signed zero, block end.
	localparam logic [7:0] MONO_CODES [19] = '{
		8'h00, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70,
		8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
		8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01
	};

	// Stereo opening: odd length so the right channel is up next.
	localparam logic [7:0] STEREO_CODES [5] = '{8'h7F, 8'hFF, 8'h55, 8'hAA, 8'h7F};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         code;
	logic               last;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample;
	logic               channel;
	logic               last_out;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [1:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int   mismatches;
	int   pending;
	int   checked;
	int   stall_cycles;
	int   codes_sent;
	int   stereo_codes;
	int   blocks_done;
	int   mode_writes;
	logic mode_now;
	logic no_idle;

	adpcm_8bit_sample_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.code     (code),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample   (sample),
		.channel  (channel),
		.last_out (last_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	adpcm_8bit_sample_decoder_checker pcm_monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code      (code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.channel   (channel),
		.last_out  (last_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.mismatches(mismatches),
		.pending   (pending),
		.checked   (checked)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
			$display("[adpcm_8bit_sample_decoder] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Sample sink with a random stall before each transaction.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Presents one code after a random gap and holds it until accepted.
	task automatic send_code(input logic [7:0] c, input logic lst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code <= c;
		last <= lst;
		do @(posedge clk); while (!in_ready);
		codes_sent++;
		if (mode_now == MODE_STEREO) begin
			stereo_codes++;
		end
		if (lst) begin
			blocks_done++;
		end
	endtask

	// Stops sending and waits until every predicted sample has come out.
	task automatic wait_for_samples();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes stereo_mode, then reads it back for the checker to compare.
	task automatic set_mode(input logic m);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_STEREO_MODE;
		pwdata <= {31'b0, m};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		mode_now = m;
		mode_writes++;
	endtask

	// Random code: quiet passages in 45% of picks that keep the step index moderate,
	// loud ones in 15% that push it to the top, the rest fully random.
	function automatic logic [7:0] make_code();
		logic [7:0] c;
		int         pick;
		c = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			c[6:4] = 3'($urandom_range(0, 3));
		end else if (pick < 60) begin
			c[6:4] = 3'($urandom_range(5, 7));
		end
		return c;
	endfunction

	// Stimulus.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		code = '0;
		last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		codes_sent = 0;
		stereo_codes = 0;
		blocks_done = 0;
		mode_writes = 0;
		mode_now = MODE_MONO;
		no_idle = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed mono block from the reset state.
		foreach (MONO_CODES[i]) begin
			send_code(MONO_CODES[i], i == $size(MONO_CODES) - 1);
		end

		// Stereo without a block end, then back to mono while the right
		// channel is still up next.
		wait_for_samples();
		set_mode(MODE_STEREO);
		foreach (STEREO_CODES[i]) begin
			send_code(STEREO_CODES[i], 1'b0);
		end
		wait_for_samples();
		set_mode(MODE_MONO);
		send_code(8'h22, 1'b0);
		send_code(8'h33, 1'b0);
		send_code(8'h44, 1'b1);

		// Random phases, alternating the mode at each boundary. Blocks are
		// long on average so step indices wander across the whole table.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_for_samples();
			set_mode(p % 2 == 0 ? MODE_STEREO : MODE_MONO);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 30 == 0) begin
					no_idle = ($urandom_range(0, 2) == 0);
				end
				send_code(make_code(), $urandom_range(0, 39) == 0);
			end
		end
		no_idle = 1'b0;
		wait_for_samples();
		repeat (10) @(posedge clk);

		$display("Run covered %0d codes (%0d in stereo mode) in %0d finished blocks.",
			codes_sent, stereo_codes, blocks_done);
		$display("%0d samples compared; stereo_mode written and read back %0d times.",
			checked, mode_writes);
		if (mismatches == 0 && pending == 0) begin
			$display("[adpcm_8bit_sample_decoder] OK");
		end else begin
			$display("[adpcm_8bit_sample_decoder] ERROR");
		end
		$finish;
	end

endmodule
